/* design/sab_pkg.sv */
package sab_pkg;

    localparam int MAX_LETTERS = 4096;
    localparam int MAX_STATES  = 8192;
    localparam int ALPHABET    = 26;

    localparam int ST_W   = 13;
    localparam int CNT_W  = 14;
    localparam int LEN_W  = 13;
    localparam int LET_W  = 5;
    localparam int SLOT_W = 18;
    localparam int ROW_W  = 13;
    localparam int LINK_W = 14;
    localparam int TGT_W  = 14;

    localparam logic [CNT_W-1:0] EDGE_SAT = 14'd16383;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_NEWST,
        S_RD1,
        S_RD1W,
        S_WALK1,
        S_LINK1,
        S_LINK1W,
        S_QCMP,
        S_CPRD,
        S_CPWR,
        S_CLONE,
        S_RD2,
        S_RD2W,
        S_WALK2,
        S_LINK2,
        S_LINK2W,
        S_FINISH,
        S_OUT
    } sab_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_NEWST,
        OP_RD_PC,
        OP_WR_PC_R,
        OP_RD_LINK_P,
        OP_LOAD_P,
        OP_RD_Q,
        OP_SET_RLINK_Q,
        OP_NEW_CLONE,
        OP_CP_RD,
        OP_CP_WR,
        OP_CLONE_META,
        OP_WR_PC_QQ,
        OP_FINISH
    } sab_op_t;

    typedef struct packed {
        sab_op_t op;
    } sab_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic bad_letter;
        logic full;
        logic pc_valid;
        logic p_is_root;
        logic len_match;
        logic tgt_is_q;
        logic cp_done;
    } sab_stat_t;

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [ST_W-1:0] st,
                                                    input logic [LET_W-1:0] c);
        logic [SLOT_W-1:0] base;
        base = {st, 5'd0} - {2'd0, st, 3'd0} + {4'd0, st, 1'b0};
        return base + {{(SLOT_W-LET_W){1'b0}}, c};
    endfunction

endpackage

/* design/sab_ctrl.sv */
module sab_ctrl
    import sab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_fire,
    input  sab_stat_t stat,
    output sab_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);

    sab_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad_letter || stat.full)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NEWST;
                end
            end
            S_NEWST:
            begin
                cmd.op     = OP_NEWST;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.op     = OP_RD_PC;
                state_next = S_RD1W;
            end
            S_RD1W:
            begin
                state_next = S_WALK1;
            end
            S_WALK1:
            begin
                if (stat.pc_valid)
                begin
                    cmd.op     = OP_RD_Q;
                    state_next = S_QCMP;
                end
                else
                begin
                    cmd.op = OP_WR_PC_R;
                    if (stat.p_is_root)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LINK1;
                    end
                end
            end
            S_LINK1:
            begin
                cmd.op     = OP_RD_LINK_P;
                state_next = S_LINK1W;
            end
            S_LINK1W:
            begin
                cmd.op     = OP_LOAD_P;
                state_next = S_RD1;
            end
            S_QCMP:
            begin
                if (stat.len_match)
                begin
                    cmd.op     = OP_SET_RLINK_Q;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_NEW_CLONE;
                    state_next = S_CPRD;
                end
            end
            S_CPRD:
            begin
                cmd.op     = OP_CP_RD;
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                cmd.op = OP_CP_WR;
                if (stat.cp_done)
                begin
                    state_next = S_CLONE;
                end
                else
                begin
                    state_next = S_CPRD;
                end
            end
            S_CLONE:
            begin
                cmd.op     = OP_CLONE_META;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.op     = OP_RD_PC;
                state_next = S_RD2W;
            end
            S_RD2W:
            begin
                state_next = S_WALK2;
            end
            S_WALK2:
            begin
                if (stat.pc_valid && stat.tgt_is_q)
                begin
                    cmd.op = OP_WR_PC_QQ;
                    if (stat.p_is_root)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LINK2;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LINK2:
            begin
                cmd.op     = OP_RD_LINK_P;
                state_next = S_LINK2W;
            end
            S_LINK2W:
            begin
                cmd.op     = OP_LOAD_P;
                state_next = S_RD2;
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* design/sab_dp.sv */
module sab_dp
    import sab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sab_cmd_t         cmd,
    input  logic [LET_W-1:0] letter,
    output sab_stat_t        stat,
    output logic [CNT_W-1:0] state_total,
    output logic [CNT_W-1:0] edge_total,
    output logic [ST_W-1:0]  last_state,
    output logic [LEN_W-1:0] prefix_length,
    output logic [1:0]       status
);

    // edge memory entry: valid bit plus target
    logic [TGT_W:0]   edge_mem [MAX_STATES*ALPHABET];
    logic [LINK_W-1:0] link_mem [MAX_STATES];
    logic [LEN_W-1:0]  len_mem  [MAX_STATES];

    logic [TGT_W:0]    edge_rd_reg;
    logic [LINK_W-1:0] link_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;

    logic [CNT_W-1:0] state_count_reg;
    logic [CNT_W-1:0] edge_count_reg;
    logic [ST_W-1:0]  last_reg;
    logic [LEN_W-1:0] seen_reg;
    logic [1:0]       status_reg;
    logic [LET_W-1:0] c_reg;
    logic [ST_W-1:0]  p_reg;
    logic [ST_W-1:0]  r_reg;
    logic [ST_W-1:0]  q_reg;
    logic [ST_W-1:0]  qq_reg;
    logic [LEN_W-1:0] lenp_reg;
    logic [LINK_W-1:0] qlink_reg;
    logic [LET_W-1:0] cp_reg;
    logic [SLOT_W-1:0] clr_reg;

    logic             e_we;
    logic [SLOT_W-1:0] e_waddr;
    logic [TGT_W:0]    e_wdata;
    logic [SLOT_W-1:0] e_raddr;
    logic             l_we;
    logic [ST_W-1:0]  l_waddr;
    logic [LINK_W-1:0] l_wdata;
    logic [ST_W-1:0]  l_raddr;
    logic             n_we;
    logic [ST_W-1:0]  n_waddr;
    logic [LEN_W-1:0] n_wdata;
    logic [ST_W-1:0]  n_raddr;
    logic [CNT_W-1:0] edge_inc;

    assign edge_inc = (edge_count_reg < EDGE_SAT) ? edge_count_reg + 1'b1 : edge_count_reg;

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = slot_addr(p_reg, c_reg);
        e_wdata = {1'b1, 1'b0, r_reg};
        e_raddr = slot_addr(p_reg, c_reg);
        l_we    = 1'b0;
        l_waddr = r_reg;
        l_wdata = '0;
        l_raddr = p_reg;
        n_we    = 1'b0;
        n_waddr = r_reg;
        n_wdata = seen_reg + 1'b1;
        n_raddr = p_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                e_we    = 1'b1;
                e_waddr = clr_reg;
                e_wdata = '0;
                l_we    = (clr_reg == '0);
                l_waddr = '0;
                l_wdata = {1'b1, {ST_W{1'b0}}};
                n_we    = (clr_reg == '0);
                n_waddr = '0;
                n_wdata = '0;
            end
            OP_NEWST:
            begin
                n_we    = 1'b1;
                n_waddr = state_count_reg[ST_W-1:0];
                l_we    = 1'b1;
                l_waddr = state_count_reg[ST_W-1:0];
            end
            OP_WR_PC_R:
            begin
                e_we = 1'b1;
            end
            OP_RD_Q:
            begin
                n_raddr = edge_rd_reg[ST_W-1:0];
                l_raddr = edge_rd_reg[ST_W-1:0];
            end
            OP_SET_RLINK_Q:
            begin
                l_we    = 1'b1;
                l_wdata = {1'b0, q_reg};
            end
            OP_CP_RD:
            begin
                e_raddr = slot_addr(q_reg, cp_reg);
            end
            OP_CP_WR:
            begin
                e_we    = 1'b1;
                e_waddr = slot_addr(qq_reg, cp_reg);
                e_wdata = edge_rd_reg;
                l_we    = 1'b1;
                l_wdata = {1'b0, qq_reg};
            end
            OP_CLONE_META:
            begin
                n_we    = 1'b1;
                n_waddr = qq_reg;
                n_wdata = lenp_reg + 1'b1;
                l_we    = 1'b1;
                l_waddr = qq_reg;
                l_wdata = qlink_reg;
            end
            OP_WR_PC_QQ:
            begin
                e_we    = 1'b1;
                e_wdata = {1'b1, 1'b0, qq_reg};
            end
            OP_FINISH:
            begin
                l_we    = (q_reg != '0) && (qq_reg != '0);
                l_waddr = q_reg;
                l_wdata = {1'b0, qq_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        edge_rd_reg <= edge_mem[e_raddr];
        if (l_we)
        begin
            link_mem[l_waddr] <= l_wdata;
        end
        link_rd_reg <= link_mem[l_raddr];
        if (n_we)
        begin
            len_mem[n_waddr] <= n_wdata;
        end
        len_rd_reg <= len_mem[n_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= 14'd1;
            edge_count_reg  <= '0;
            last_reg        <= '0;
            seen_reg        <= '0;
            status_reg      <= STATUS_OK;
            c_reg           <= '0;
            p_reg           <= '0;
            r_reg           <= '0;
            q_reg           <= '0;
            qq_reg          <= '0;
            lenp_reg        <= '0;
            qlink_reg       <= '0;
            cp_reg          <= '0;
            clr_reg         <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                OP_LATCH:
                begin
                    c_reg <= letter;
                    if (letter >= LET_W'(ALPHABET))
                    begin
                        status_reg <= STATUS_RANGE;
                    end
                    else if ({1'b0, seen_reg} >= 14'(MAX_LETTERS)
                             || (state_count_reg + 2'd2) > 14'(MAX_STATES))
                    begin
                        status_reg <= STATUS_FULL;
                    end
                    else
                    begin
                        status_reg <= STATUS_OK;
                    end
                end
                OP_NEWST:
                begin
                    r_reg           <= state_count_reg[ST_W-1:0];
                    state_count_reg <= state_count_reg + 1'b1;
                    p_reg           <= last_reg;
                    q_reg           <= '0;
                    qq_reg          <= '0;
                end
                OP_WR_PC_R:
                begin
                    edge_count_reg <= edge_inc;
                end
                OP_LOAD_P:
                begin
                    p_reg <= link_rd_reg[ST_W-1:0];
                end
                OP_RD_Q:
                begin
                    q_reg    <= edge_rd_reg[ST_W-1:0];
                    lenp_reg <= len_rd_reg;
                end
                OP_NEW_CLONE:
                begin
                    qq_reg          <= state_count_reg[ST_W-1:0];
                    state_count_reg <= state_count_reg + 1'b1;
                    edge_count_reg  <= edge_inc;
                    qlink_reg       <= link_rd_reg;
                    cp_reg          <= '0;
                end
                OP_CP_WR:
                begin
                    cp_reg <= cp_reg + 1'b1;
                end
                OP_FINISH:
                begin
                    last_reg <= r_reg;
                    seen_reg <= seen_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // p-length is read with edge in the same cycle during RD1; latch on RD_Q
    always_comb
    begin
        stat.clear_done = (clr_reg == SLOT_W'(MAX_STATES*ALPHABET - 1));
        stat.bad_letter = (status_reg == STATUS_RANGE);
        stat.full       = (status_reg == STATUS_FULL);
        stat.pc_valid   = edge_rd_reg[TGT_W];
        stat.p_is_root  = (p_reg == '0);
        stat.len_match  = (lenp_reg + 1'b1 == len_rd_reg);
        stat.tgt_is_q   = (edge_rd_reg[ST_W-1:0] == q_reg);
        stat.cp_done    = (cp_reg == LET_W'(ALPHABET - 1));
    end

    assign state_total   = state_count_reg;
    assign edge_total    = edge_count_reg;
    assign last_state    = last_reg;
    assign prefix_length = seen_reg;
    assign status        = status_reg;

endmodule

/* design/suffix_automaton_builder_top.sv */
// channel | dir | tdata / tuser
// s_axis  | in  | tdata[4:0] letter
// m_axis  | out | tdata[13:0] state_total, [27:14] edge_total, [40:28] last_state,
//         |     | [53:41] prefix_length, [55:54] status
// after reset a clearing pass sweeps the edge memory, input held off
// a letter adds a state, then walks suffix links writing edges until the walk stops on an edge,
// and for a clone copies every edge slot, then redirects edges along further suffix-link steps
// a rejected letter skips the build; the pace is set by the single read port of the edge memory
// one letter at a time; the result holds until taken
module suffix_automaton_builder_top
    import sab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // letter
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // state_total, edge_total, last_state, prefix_length, status
);

    sab_cmd_t         cmd;
    sab_stat_t        stat;
    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] state_total;
    logic [CNT_W-1:0] edge_total;
    logic [ST_W-1:0]  last_state;
    logic [LEN_W-1:0] prefix_length;
    logic [1:0]       status;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    sab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    sab_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .letter        (s_axis_tdata[LET_W-1:0]),
        .stat          (stat),
        .state_total   (state_total),
        .edge_total    (edge_total),
        .last_state    (last_state),
        .prefix_length (prefix_length),
        .status        (status)
    );

    assign m_axis_tdata = {status, prefix_length, last_state, edge_total, state_total};

endmodule
